// File: src/tasm_pkg.sv
package tasm_pkg;

  // Block dimensions.
  localparam int AXES         = 3;
  localparam int TIMER_BITS   = 16;
  localparam int KIND_W       = 2;
  localparam int AXIS_W       = 2;
  localparam int PERIOD_W     = 17;
  localparam int POS_W        = 32;
  localparam int STEPS_W      = 32;
  localparam int MIN_PERIOD_W = 16;
  localparam int INVERT_W     = AXES;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int CALC_W       = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

  // Reset values.
  localparam logic [PERIOD_W-1:0]     PERIOD_RST     = PERIOD_W'(4000);
  localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RST = MIN_PERIOD_W'(10);
  localparam logic [INVERT_W-1:0]     INVERT_RST     = INVERT_W'(4);

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_SET  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'b1;

  typedef struct packed {
    kind_e_t                   kind;
    logic [AXIS_W-1:0]         axis;
    logic [PERIOD_W-1:0]       period;
    logic signed [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [AXES-1:0] step_pins;
    logic [AXES-1:0] dir_pins;
    logic [AXES-1:0] busy_mask;
    logic [AXES-1:0] done_mask;
    logic            accepted;
  } out_item_t;

  // Command broadcast to each axis lane.
  typedef struct packed {
    kind_e_t                 op;
    logic                    sel;
    logic [PERIOD_W-1:0]     period;
    logic signed [POS_W-1:0] position;
  } lane_cmd_t;

  // Status returned by each axis lane, after the request is applied.
  typedef struct packed {
    logic step;
    logic dir;
    logic busy;
    logic done;
    logic accepted;
  } lane_stat_t;

endpackage

// File: src/tasm_axis.sv
module tasm_axis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  tasm_pkg::lane_cmd_t                  cmd,
  input  logic [tasm_pkg::MIN_PERIOD_W-1:0]    min_period,
  output tasm_pkg::lane_stat_t                 stat
);
  import tasm_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    run_r, run_nxt;
  logic                    dir_r, dir_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [STEPS_W-1:0]      done_cnt_r, done_cnt_nxt;
  logic [STEPS_W-1:0]      want_r, want_nxt;
  logic [PERIOD_W-1:0]     per_r, per_nxt;
  logic [TIMER_BITS-1:0]   tick_r, tick_nxt;

  logic [POS_W:0]          diff;
  logic [POS_W:0]          mag;
  logic                    diff_neg;
  logic [STEPS_W-1:0]      step_dist;
  logic                    move_ok;
  logic [CALC_W-1:0]       reload_full;
  logic [CALC_W-1:0]       cmp_full;
  logic [TIMER_BITS-1:0]   reload;
  logic [TIMER_BITS-1:0]   cmp_nxt;
  logic [STEPS_W-1:0]      done_inc;
  logic                    done_now;

  // Signed distance from the stored position, one bit wider so it is exact.
  assign diff      = {cmd.position[POS_W-1], cmd.position} - {pos_r[POS_W-1], pos_r};
  assign diff_neg  = diff[POS_W];
  assign mag       = diff_neg ? (~diff + 1'b1) : diff;
  assign step_dist = mag[STEPS_W-1:0];

  assign move_ok  = cmd.sel && !busy_r && (cmd.period > PERIOD_W'(min_period));

  // Timer reload value of the current period, wrapped to the timer width.
  assign reload_full = CALC_W'(per_r) - 1'b1;
  assign reload      = reload_full[TIMER_BITS-1:0];
  assign done_inc    = done_cnt_r + 1'b1;

  // State update for one request.
  always_comb begin
    busy_nxt     = busy_r;
    run_nxt      = run_r;
    dir_nxt      = dir_r;
    pos_nxt      = pos_r;
    done_cnt_nxt = done_cnt_r;
    want_nxt     = want_r;
    per_nxt      = per_r;
    tick_nxt     = tick_r;
    done_now     = 1'b0;
    unique case (cmd.op)
      KIND_MOVE: begin
        if (move_ok) begin
          dir_nxt      = diff_neg;
          pos_nxt      = cmd.position;
          done_cnt_nxt = '0;
          want_nxt     = step_dist;
          per_nxt      = cmd.period;
          tick_nxt     = '0;
          if (step_dist == '0) begin
            busy_nxt = 1'b0;
            run_nxt  = 1'b0;
            done_now = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            run_nxt  = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (run_r) begin
          if (tick_r == reload) begin
            tick_nxt     = '0;
            done_cnt_nxt = done_inc;
            if (done_inc >= want_r) begin
              run_nxt  = 1'b0;
              busy_nxt = 1'b0;
              done_now = 1'b1;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
      end
      KIND_SET: begin
        if (cmd.sel) begin
          run_nxt  = 1'b0;
          busy_nxt = 1'b0;
          pos_nxt  = cmd.position;
        end
      end
      default: begin
      end
    endcase
  end

  // Step pin compare value of the period after the update.
  assign cmp_full = CALC_W'(per_nxt >> 1) - 1'b1;
  assign cmp_nxt  = cmp_full[TIMER_BITS-1:0];

  always_comb begin
    stat.step     = run_nxt && (tick_nxt < cmp_nxt);
    stat.dir      = dir_nxt;
    stat.busy     = busy_nxt;
    stat.done     = done_now;
    stat.accepted = (cmd.op == KIND_MOVE) && move_ok;
  end

  // Lane state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      run_r      <= 1'b0;
      dir_r      <= 1'b0;
      pos_r      <= '0;
      done_cnt_r <= '0;
      want_r     <= '0;
      per_r      <= PERIOD_RST;
      tick_r     <= '0;
    end else if (en) begin
      busy_r     <= busy_nxt;
      run_r      <= run_nxt;
      dir_r      <= dir_nxt;
      pos_r      <= pos_nxt;
      done_cnt_r <= done_cnt_nxt;
      want_r     <= want_nxt;
      per_r      <= per_nxt;
      tick_r     <= tick_nxt;
    end
  end

endmodule

// File: src/three_axis_stepper_move_generator.sv
// Channel | Ports                                  | Moves
// --------+----------------------------------------+----------------------------------
// input   | in_valid, in_ready, in_data            | move, tick, set-position requests
// result  | out_valid, out_ready, out_data         | pin levels and status per request
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// One request per clock cycle while the output is not stalled: each request is
// registered in the input register, applied to all axis lanes in parallel as it moves
// on, and its result lands in the output register that drives out_valid.
// Reset is synchronous and active low; it restores every axis and both registers.
// A stalled output holds one result while one more request waits in the input register.
module three_axis_stepper_move_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tasm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tasm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tasm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tasm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tasm_pkg::*;

  logic                    s1_valid_r, s1_valid_nxt;
  in_item_t                s1_item_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;
  logic [INVERT_W-1:0]     invert_r;
  logic [MIN_PERIOD_W-1:0] min_period_r;

  logic                    in_fire;
  logic                    out_room;
  logic                    s1_fire;
  lane_stat_t              stat [AXES];

  // Handshake control.
  assign out_room = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_room;
  assign in_ready = !s1_valid_r || out_room;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !out_room);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r     <= INVERT_RST;
      min_period_r <= MIN_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIR_INVERT: invert_r     <= cfg_data[INVERT_W-1:0];
        CFG_MIN_PERIOD: min_period_r <= cfg_data[MIN_PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // One lane per axis, all updated together.
  for (genvar i = 0; i < AXES; i++) begin : g_axis
    lane_cmd_t cmd;
    always_comb begin
      cmd.op       = s1_item_r.kind;
      cmd.sel      = (32'(s1_item_r.axis) == i);
      cmd.period   = s1_item_r.period;
      cmd.position = s1_item_r.position;
    end
    tasm_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (s1_fire),
      .cmd        (cmd),
      .min_period (min_period_r),
      .stat       (stat[i])
    );
  end

  // Gather lane status into the result.
  always_comb begin
    out_item_nxt.accepted = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      out_item_nxt.step_pins[i] = stat[i].step;
      out_item_nxt.dir_pins[i]  = stat[i].dir ^ invert_r[i];
      out_item_nxt.busy_mask[i] = stat[i].busy;
      out_item_nxt.done_mask[i] = stat[i].done;
      out_item_nxt.accepted     = out_item_nxt.accepted | stat[i].accepted;
    end
  end

  // Control registers of the input and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
